// ===== src/cmric_pkg.sv =====
// ----------------------------------------------------------------------------
// cmric_pkg
// shared types, constants and the quarter-wave sine table generator for the return counter
// ----------------------------------------------------------------------------
package cmric_pkg;

  localparam int unsigned FracBits     = 24;
  localparam int unsigned TabDepth     = 1024;
  localparam int unsigned TabIdxW      = 10;
  localparam logic [31:0] InvTwoPiQ32  = 32'd683565276;
  localparam logic [31:0] HalfPiQ30    = 32'd1686629713;

  typedef enum logic [0:0] {
    CFG_ITER_LIMIT = 1'b0,
    CFG_TOLERANCE  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL1,
    ST_MUL2,
    ST_UPD,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // latch input word, clear offset and step count
    logic look;      // table read for current phase
    logic mul1;      // K * magnitude
    logic mul2;      // scale by 1/(2 pi)
    logic upd;       // offset update, return test, step count
    logic acc;       // fold count into running sum
    logic div_start; // start mean division
    logic div_step;  // one quotient bit
    logic clear;     // clear sum after mean
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic returned;
    logic limit_hit;
    logic div_done;
    logic is_last;
  } sts_t;

  // integer Taylor series for sin in Q30, terms truncated
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [FracBits:0] quarter_sine(input logic [TabIdxW:0] i);
    logic [63:0] x;
    logic [63:0] s;
    x = (64'(HalfPiQ30) * 64'(i)) / 64'(TabDepth);
    s = sine_q30(x);
    s = (s + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
    return s[FracBits:0];
  endfunction

endpackage

// ===== src/cmric_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmric_ctrl
// sequencer for trial iteration, accumulation and mean division
// ----------------------------------------------------------------------------
module cmric_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output cmric_pkg::cmd_t cmd,
  input  cmric_pkg::sts_t sts
);
  import cmric_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (sts.limit_zero) state_nxt = ST_ACC;
        else state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_UPD;
      ST_UPD: begin
        if (sts.returned || sts.limit_hit) state_nxt = ST_ACC;
        else state_nxt = ST_LOOK;
      end
      ST_ACC: begin
        if (sts.is_last) state_nxt = ST_DIV;
        else state_nxt = ST_IDLE;
      end
      ST_DIV: if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_LOOK: cmd.look = 1'b1;
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_UPD:  cmd.upd = 1'b1;
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.div_start = sts.is_last;
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.clear = !out_stall;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/cmric_dpath.sv =====
// ----------------------------------------------------------------------------
// cmric_dpath
// map state, K and 1/(2 pi) multipliers, return test, running sum and serial divider
// ----------------------------------------------------------------------------
module cmric_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_sel,
  input  logic [23:0]           cfg_wdata,
  input  logic [24:0]           in_drive_omega,
  input  logic [27:0]           in_coupling_k,
  input  logic [23:0]           in_start_value,
  input  logic                  in_last_trial,
  output logic [15:0]           out_mean_iterations,
  input  cmric_pkg::cmd_t       cmd,
  output cmric_pkg::sts_t       sts
);
  import cmric_pkg::*;

  logic [15:0] limit_r;
  logic [23:0] tol_r;
  logic [24:0] omega_r;
  logic [27:0] k_r;
  logic [23:0] z0_r;
  logic        last_r;
  logic [47:0] d_r;
  logic [15:0] step_r;
  logic [15:0] count_r;
  logic        neg_r;
  logic [24:0] mag_r;
  logic [52:0] prod_r;
  logic [28:0] term_r;
  logic [31:0] sum_r;
  logic [15:0] trials_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [5:0]  bit_r;
  logic [15:0] mean_r;

  logic [FracBits:0] sine_rom [0:TabDepth];

  logic [23:0] phase;
  logic [11:0] idx;
  logic [TabIdxW:0] tab_addr;
  logic [47:0] d_nxt;
  logic [47:0] abs_d;
  logic [32:0] sum_ext;
  logic [32:0] rem_sh;
  logic [60:0] prod2;

  // quarter-wave table contents are fixed, filled once at start
  initial begin
    for (int i = 0; i <= int'(TabDepth); i++) sine_rom[i] = quarter_sine(11'(i));
  end

  assign phase = z0_r + d_r[23:0];
  assign idx = phase[23:12];
  assign tab_addr = idx[10] ? (11'(TabDepth) - {1'b0, idx[9:0]}) : {1'b0, idx[9:0]};
  assign prod2 = 61'(prod_r[52:FracBits]) * 61'(InvTwoPiQ32);
  assign d_nxt = neg_r ? d_r + 48'(omega_r) + 48'(term_r)
                       : d_r + 48'(omega_r) - 48'(term_r);
  assign abs_d = d_nxt[47] ? (48'd0 - d_nxt) : d_nxt;
  assign sum_ext = {1'b0, sum_r} + 33'(count_r);
  assign rem_sh = {rem_r, quo_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'd1000;
      tol_r <= 24'd16777;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_sel))
        CFG_ITER_LIMIT: limit_r <= cfg_wdata[15:0];
        CFG_TOLERANCE:  tol_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      omega_r <= in_drive_omega;
      k_r <= in_coupling_k;
      z0_r <= in_start_value;
      last_r <= in_last_trial;
      d_r <= '0;
      step_r <= '0;
      count_r <= limit_r;
    end
    if (cmd.look) begin
      mag_r <= sine_rom[tab_addr];
      neg_r <= idx[11];
    end
    if (cmd.mul1) prod_r <= 53'(k_r) * 53'(mag_r);
    if (cmd.mul2) term_r <= prod2[60:32];
    if (cmd.upd) begin
      d_r <= d_nxt;
      step_r <= step_r + 16'd1;
      if (abs_d[23:0] < tol_r) count_r <= step_r;
    end
  end

  assign sts.limit_zero = (limit_r == 16'd0);
  assign sts.returned = (abs_d[23:0] < tol_r);
  assign sts.limit_hit = (step_r + 16'd1 == limit_r);
  assign sts.is_last = last_r;
  assign sts.div_done = (bit_r == 6'd0);

  // sum and trial count with saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      trials_r <= '0;
    end else if (cmd.acc) begin
      sum_r <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      if (trials_r != 16'hFFFF) trials_r <= trials_r + 16'd1;
    end else if (cmd.clear) begin
      sum_r <= '0;
      trials_r <= '0;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      rem_r <= '0;
      bit_r <= 6'd32;
    end else if (cmd.div_step && bit_r != 6'd0) begin
      bit_r <= bit_r - 6'd1;
      if (rem_sh >= 33'(trials_r)) begin
        rem_r <= 32'(rem_sh - 33'(trials_r));
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end else if (cmd.div_step) begin
      mean_r <= (quo_r[31:16] != 16'd0) ? 16'hFFFF : quo_r[15:0];
    end
  end

  assign out_mean_iterations = mean_r;

endmodule

// ===== src/circle_map_return_iteration_count_unit.sv =====
// ----------------------------------------------------------------------------
// circle_map_return_iteration_count_unit
// circle map trial runner with per-pixel mean of return counts
// ----------------------------------------------------------------------------
// One word is one trial. Each map step of a trial runs table read, two
// multiplier stages and offset update, until a return or the iteration
// limit; a last trial then runs the serial division before the mean is
// shown. The map step loop sets the rate; one trial is in work at a time.
module circle_map_return_iteration_count_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [24:0] in_drive_omega,
  input  logic [27:0] in_coupling_k,
  input  logic [23:0] in_start_value,
  input  logic        in_last_trial,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_mean_iterations
);
  import cmric_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cmric_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  cmric_dpath u_dpath (
    .clk, .rst_n, .cfg_we, .cfg_sel(cfg_index), .cfg_wdata,
    .in_drive_omega, .in_coupling_k, .in_start_value, .in_last_trial,
    .out_mean_iterations, .cmd, .sts
  );

endmodule

// ===== test/cmric_checker.sv =====
// ----------------------------------------------------------------------------
// cmric_checker
// Watches the trial, result and register ports of the circle map return
// counter. It predicts each pixel mean from its own fixed point model of the
// map and compares every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module cmric_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [24:0] in_drive_omega,
  input  logic [27:0] in_coupling_k,
  input  logic [23:0] in_start_value,
  input  logic        in_last_trial,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_mean_iterations,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmric_pkg::*;

  logic [24:0] sine_tab [0:1024];
  logic [15:0] iter_limit;
  logic [23:0] tolerance;
  logic [32:0] count_total;
  logic [15:0] trial_total;
  logic [15:0] mean_q [$];

  function automatic logic [63:0] taylor_sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] acc;
    x2 = (x * x) >> 30;
    t = x;
    acc = x;
    for (int n = 1; n <= 12; n++) begin
      t = (t * x2) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = (acc >= t) ? acc - t : 64'd0;
      else acc = acc + t;
    end
    return acc;
  endfunction

  // map steps until the offset comes back within tolerance of the start
  function automatic logic [15:0] return_count(input logic [24:0] omega,
                                               input logic [27:0] kval,
                                               input logic [23:0] z0);
    logic [47:0] d;
    logic [47:0] absd;
    logic [23:0] ph;
    logic [11:0] idx;
    logic [63:0] mag;
    logic [63:0] term;
    int cnt;
    d = '0;
    cnt = iter_limit;
    for (int i = 0; i < int'(iter_limit); i++) begin
      ph = z0 + d[23:0];
      idx = ph[23:12];
      mag = idx[10] ? 64'(sine_tab[1024 - int'(idx[9:0])]) : 64'(sine_tab[idx[9:0]]);
      term = (64'(kval) * mag) >> FracBits;
      term = (term * 64'(InvTwoPiQ32)) >> 32;
      if (idx[11]) d = d + 48'(omega) + term[47:0];
      else d = d + 48'(omega) - term[47:0];
      absd = d[47] ? -d : d;
      if (absd[23:0] < tolerance) begin
        cnt = i;
        break;
      end
    end
    return 16'(cnt);
  endfunction

  initial begin
    logic [63:0] x;
    logic [63:0] s;
    for (int i = 0; i <= 1024; i++) begin
      x = (64'(HalfPiQ30) * 64'(i)) / 64'(TabDepth);
      s = taylor_sin_q30(x);
      s = (s + 64'd32) >> 6;
      sine_tab[i] = s[24:0];
    end
  end

  always @(posedge clk) begin
    logic [15:0] cnt;
    logic [32:0] mean;
    logic [15:0] want;
    if (!rst_n) begin
      iter_limit <= 16'd1000;
      tolerance <= 24'd16777;
      count_total <= '0;
      trial_total <= '0;
      mean_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ITER_LIMIT: iter_limit <= cfg_wdata[15:0];
          CFG_TOLERANCE:  tolerance <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected result word, actual mean %0d", $time,
                   out_mean_iterations);
          fail_count <= fail_count + 1;
        end else begin
          want = mean_q.pop_front();
          if (want !== out_mean_iterations) begin
            $display("%0t: mean mismatch, expected %0d actual %0d", $time, want,
                     out_mean_iterations);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        cnt = return_count(in_drive_omega, in_coupling_k, in_start_value);
        mean = count_total + 33'(cnt);
        if (mean > 33'hFFFFFFFF) mean = 33'hFFFFFFFF;
        if (in_last_trial) begin
          mean = mean / 33'(trial_total == 16'hFFFF ? trial_total : trial_total + 1);
          mean_q.push_back(mean > 33'hFFFF ? 16'hFFFF : mean[15:0]);
          count_total <= '0;
          trial_total <= '0;
        end else begin
          count_total <= mean;
          if (trial_total != 16'hFFFF) trial_total <= trial_total + 1;
        end
      end
      pending <= mean_q.size();
    end
  end
endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the circle map return counter: directed trials at the field
// extremes and register settings, then random pixels under random stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmric_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [24:0] in_drive_omega;
  logic [27:0] in_coupling_k;
  logic [23:0] in_start_value;
  logic        in_last_trial;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_mean_iterations;
  int          fail_count;
  int          pending;
  logic        hold_req;
  logic        burst_mode;

  circle_map_return_iteration_count_unit uut (.*);

  cmric_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("circle_map_return_iteration_count_unit verification failed");
    $finish;
  end

  // receiver: short stalls mostly, some long, plus a requested hold-off
  initial begin
    int run;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
      end
      out_stall = 1'b0;
      run = $urandom_range(1, 30);
      repeat (run) @(negedge clk);
      if (!hold_req && $urandom_range(0, 3) != 0) begin
        out_stall = 1'b1;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 3);
        repeat (run) @(negedge clk);
      end
    end
  end

  task automatic send_trial(input logic [24:0] omega, input logic [27:0] kval,
                            input logic [23:0] z0, input logic last);
    int gap;
    in_valid = 1'b1;
    in_drive_omega = omega;
    in_coupling_k = kval;
    in_start_value = z0;
    in_last_trial = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!burst_mode && $urandom_range(0, 1) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // quiet the input, let all results drain, then write both registers
  task automatic set_regs(input logic [15:0] limit, input logic [23:0] tol);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_ITER_LIMIT;
    cfg_wdata = 24'(limit);
    @(negedge clk);
    cfg_index = CFG_TOLERANCE;
    cfg_wdata = tol;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_pixels(input int n);
    for (int i = 0; i < n; i++)
      send_trial(25'($urandom_range(0, 16777216)), 28'($urandom_range(0, 210828714)),
                 24'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ITER_LIMIT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_drive_omega = '0;
    in_coupling_k = '0;
    in_start_value = '0;
    in_last_trial = 1'b0;
    hold_req = 1'b0;
    burst_mode = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset register values
    send_trial(25'd0, 28'd0, 24'd0, 1'b0);
    send_trial(25'd16777216, 28'd210828714, 24'hFFFFFF, 1'b0);
    send_trial(25'd8388608, 28'd100000000, 24'h800000, 1'b0);
    send_trial(25'h0AAAAAA, 28'h5555555, 24'h555555, 1'b1);
    // zero limit: no steps taken
    set_regs(16'd0, 24'd0);
    send_trial(25'd123456, 28'd654321, 24'hABCDEF, 1'b0);
    send_trial(25'd16777216, 28'd0, 24'd0, 1'b1);
    // single step, nothing ever returns
    set_regs(16'd1, 24'd0);
    send_trial(25'd16777215, 28'd210828714, 24'h3FFFFF, 1'b1);
    // widest tolerance with the largest limit returns at once
    set_regs(16'd65535, 24'hFFFFFF);
    send_trial(25'd5, 28'd210828714, 24'hC00000, 1'b0);
    send_trial(25'd16777216, 28'd7, 24'h400000, 1'b0);
    send_trial(25'h1555555, 28'hAAAAAAA, 24'hAAAAAA, 1'b1);
    // one full length trial with no return
    set_regs(16'd65535, 24'd0);
    send_trial(25'd0, 28'd0, 24'd0, 1'b1);
    // short limit with integer omega
    set_regs(16'd40, 24'd1);
    send_trial(25'd16777216, 28'd210828714, 24'h000001, 1'b0);
    send_trial(25'd0, 28'd210828714, 24'h7FFFFF, 1'b0);
    send_trial(25'd16777216, 28'd0, 24'h123456, 1'b1);

    for (int p = 0; p < 8; p++) begin
      set_regs(16'($urandom_range(1, 64)),
               (p == 2) ? 24'hFFFFFF : 24'($urandom_range(0, 1 << $urandom_range(8, 23))));
      if (p == 4) begin
        hold_req = 1'b1;
        burst_mode = 1'b1;
      end
      random_pixels(21);
      burst_mode = 1'b0;
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("circle_map_return_iteration_count_unit verification clean");
    end else begin
      $display("circle_map_return_iteration_count_unit verification failed");
    end
    $finish;
  end
endmodule
